FILE: sv/lmct_pkg.sv
// Shared types and constants for the LRU mapping cache table.
`default_nettype none
package lmct_pkg;
    localparam int TableDepth = 64;
    localparam int SectorsPerPage = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [2:0] OP_QUERY = 3'd0;
    localparam logic [2:0] OP_RETRIEVE = 3'd1;
    localparam logic [2:0] OP_RESERVE = 3'd2;
    localparam logic [2:0] OP_FILL = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;
    localparam logic [2:0] OP_CLEAN = 3'd5;
    localparam logic [2:0] OP_EVICT = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_MISSING = 3'd1;
    localparam logic [2:0] ERR_DUP = 3'd2;
    localparam logic [2:0] ERR_FULL = 3'd3;
    localparam logic [2:0] ERR_EMPTY = 3'd4;

    localparam logic [15:0] BitmapMask = 16'((64'd1 << SectorsPerPage) - 64'd1);

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] stream_number;
        logic [31:0] logical_page;
        logic [31:0] physical_page;
        logic [15:0] sector_bitmap;
    } req_t;

    typedef struct packed {
        logic is_valid;
        logic is_waiting;
        logic is_dirty;
        logic [31:0] found_physical_page;
        logic [15:0] found_bitmap;
        logic slot_free;
        logic [2:0] evicted_stream;
        logic [31:0] evicted_logical_page;
        logic [2:0] error_code;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, clear scan
        logic scan;      // examine slot at scan index
        logic scan_clr;  // restart scan index
        logic rank;      // adjust rank of slot at scan index
        logic commit;    // write slot, build result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic need_rank;
    } sts_t;
endpackage
`default_nettype wire

FILE: sv/lmct_ctrl.sv
// Controller state machine sequencing the slot scan, rank pass and commit.
`default_nettype none
module lmct_ctrl
    import lmct_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_xfer,
    input  wire logic out_busy,
    input  wire sts_t sts,
    output cmd_t cmd,
    output logic s_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SETTLE = 3'd2;
    localparam logic [2:0] ST_RANK = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = in_xfer;
                if (in_xfer) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    cmd.scan_clr = 1'b1;
                    state_next = ST_SETTLE;
                end
            end
            // last slot read is evaluated here
            ST_SETTLE: begin
                state_next = ST_RANK;
            end
            ST_RANK: begin
                if (!sts.need_rank) begin
                    state_next = ST_FETCH;
                end else begin
                    cmd.rank = 1'b1;
                    if (sts.scan_last) state_next = ST_FETCH;
                end
            end
            // read the result slot
            ST_FETCH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> state_reg == ST_IDLE)
        else $error("commit not followed by idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> state_reg == ST_IDLE)
        else $error("transfer accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !out_busy)
        else $error("commit over pending result");
endmodule
`default_nettype wire

FILE: sv/lmct_dp.sv
// Datapath: slot arrays, scan, rank adjustment and result register.
`default_nettype none
module lmct_dp
    import lmct_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t cmd,
    input  wire req_t req_in,
    input  wire logic cfg_we,
    input  wire logic [6:0] cfg_data,
    input  wire logic out_xfer,
    output sts_t sts,
    output logic out_busy,
    output rsp_t rsp
);
    logic [TableDepth-1:0] used_reg, waiting_reg, dirty_reg;
    logic [2:0] strm_mem [TableDepth];
    logic [31:0] lpage_mem [TableDepth];
    logic [31:0] ppage_mem [TableDepth];
    logic [15:0] bmap_mem [TableDepth];
    logic [IdxW-1:0] rank_mem [TableDepth];

    logic [6:0] cap_reg;
    logic [CntW-1:0] count_reg;
    req_t req_reg;
    logic [IdxW-1:0] idx_reg, idx_d_reg;
    logic scan_vld_reg, rank_vld_reg;
    logic hit_reg, free_found_reg, best_found_reg;
    logic [IdxW-1:0] hit_idx_reg, free_idx_reg, best_idx_reg, best_rank_reg, hit_rank_reg;
    logic out_busy_reg;
    rsp_t rsp_reg;

    logic [2:0] strm_rd_reg;
    logic [31:0] lpage_rd_reg, ppage_rd_reg;
    logic [15:0] bmap_rd_reg;
    logic [IdxW-1:0] rank_rd_reg;
    logic [IdxW-1:0] rd_addr, rank_waddr, rank_wdata;
    logic rank_we, add_slot;

    logic [CntW-1:0] eff_cap;
    logic key_eq, hit_valid, do_rank, full;
    logic [2:0] op;

    assign op = req_reg.req_type;
    assign eff_cap = (cap_reg > 7'(TableDepth)) ? CntW'(TableDepth) : CntW'(cap_reg);
    assign key_eq = used_reg[idx_d_reg] && strm_rd_reg == req_reg.stream_number
                    && lpage_rd_reg == req_reg.logical_page;
    assign hit_valid = hit_reg && !waiting_reg[hit_idx_reg];
    assign full = count_reg >= eff_cap;
    assign do_rank = (op == OP_RETRIEVE && hit_valid)
                  || (op == OP_RESERVE && !hit_reg && !full && free_found_reg);
    assign add_slot = cmd.commit && op == OP_RESERVE && do_rank;
    assign sts.scan_last = idx_reg == IdxW'(TableDepth - 1);
    assign sts.need_rank = do_rank;
    assign out_busy = out_busy_reg;
    assign rsp = rsp_reg;

    // one read address for all slot arrays: walk index, else the result slot
    assign rd_addr = (cmd.scan || cmd.rank) ? idx_reg
                   : ((op == OP_EVICT) ? best_idx_reg : hit_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 7'(TableDepth);
        end else if (cfg_we) begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_vld_reg <= 1'b0;
            rank_vld_reg <= 1'b0;
        end else begin
            scan_vld_reg <= cmd.scan;
            rank_vld_reg <= cmd.rank;
        end
    end

    always_ff @(posedge aclk) begin
        idx_d_reg <= idx_reg;
        if (cmd.load) begin
            req_reg <= req_in;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            hit_idx_reg <= '0;
            best_idx_reg <= '0;
        end else if (cmd.scan || cmd.rank) begin
            idx_reg <= cmd.scan_clr ? '0 : idx_reg + 1'b1;
        end
        if (scan_vld_reg) begin
            if (key_eq && !hit_reg) begin
                hit_reg <= 1'b1;
                hit_idx_reg <= idx_d_reg;
                hit_rank_reg <= rank_rd_reg;
            end
            if (!used_reg[idx_d_reg] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg <= idx_d_reg;
            end
            if (used_reg[idx_d_reg] && (!best_found_reg || rank_rd_reg > best_rank_reg)) begin
                best_found_reg <= 1'b1;
                best_idx_reg <= idx_d_reg;
                best_rank_reg <= rank_rd_reg;
            end
        end
    end

    // rank read-modify-write: the write lands in the cycle after the read
    always_comb begin
        rank_we = 1'b0;
        rank_waddr = idx_d_reg;
        rank_wdata = rank_rd_reg;
        if (rank_vld_reg && used_reg[idx_d_reg]) begin
            if (op == OP_RESERVE) begin
                rank_we = 1'b1;
                rank_wdata = rank_rd_reg + 1'b1;
            end else if (idx_d_reg == hit_idx_reg) begin
                rank_we = 1'b1;
                rank_wdata = '0;
            end else if (rank_rd_reg < hit_rank_reg) begin
                rank_we = 1'b1;
                rank_wdata = rank_rd_reg + 1'b1;
            end
        end else if (add_slot) begin
            rank_we = 1'b1;
            rank_waddr = free_idx_reg;
            rank_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
        rank_rd_reg <= rank_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (add_slot) begin
            strm_mem[free_idx_reg] <= req_reg.stream_number;
            lpage_mem[free_idx_reg] <= req_reg.logical_page;
        end
        strm_rd_reg <= strm_mem[rd_addr];
        lpage_rd_reg <= lpage_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && ((op == OP_FILL && hit_reg) || (op == OP_UPDATE && hit_valid))) begin
            ppage_mem[hit_idx_reg] <= req_reg.physical_page;
            bmap_mem[hit_idx_reg] <= req_reg.sector_bitmap & BitmapMask;
        end
        ppage_rd_reg <= ppage_mem[rd_addr];
        bmap_rd_reg <= bmap_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            waiting_reg <= '0;
            dirty_reg <= '0;
            count_reg <= '0;
        end else if (cmd.commit) begin
            case (op)
                OP_RESERVE: begin
                    if (do_rank) begin
                        used_reg[free_idx_reg] <= 1'b1;
                        waiting_reg[free_idx_reg] <= 1'b1;
                        dirty_reg[free_idx_reg] <= 1'b0;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_FILL: begin
                    if (hit_reg) begin
                        waiting_reg[hit_idx_reg] <= 1'b0;
                        dirty_reg[hit_idx_reg] <= 1'b0;
                    end
                end
                OP_UPDATE: if (hit_valid) dirty_reg[hit_idx_reg] <= 1'b1;
                OP_CLEAN: if (hit_valid) dirty_reg[hit_idx_reg] <= 1'b0;
                OP_EVICT: begin
                    if (count_reg != '0 && best_found_reg) begin
                        used_reg[best_idx_reg] <= 1'b0;
                        waiting_reg[best_idx_reg] <= 1'b0;
                        dirty_reg[best_idx_reg] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    rsp_t r;
    logic [CntW-1:0] cnt_after;
    logic [31:0] new_pp;
    logic [15:0] new_bm;
    always_comb begin
        r = '0;
        cnt_after = count_reg;
        new_pp = req_reg.physical_page;
        new_bm = req_reg.sector_bitmap & BitmapMask;
        case (op)
            OP_QUERY, OP_RETRIEVE, OP_FILL, OP_UPDATE, OP_CLEAN: begin
                if (hit_reg) begin
                    r.is_valid = !waiting_reg[hit_idx_reg];
                    r.is_waiting = waiting_reg[hit_idx_reg];
                    if (!waiting_reg[hit_idx_reg]) begin
                        r.is_dirty = dirty_reg[hit_idx_reg];
                        r.found_physical_page = ppage_rd_reg;
                        r.found_bitmap = bmap_rd_reg;
                    end
                end
                if (op == OP_QUERY || op == OP_RETRIEVE) begin
                    if (!hit_valid) r.error_code = ERR_MISSING;
                end else if (op == OP_FILL ? !hit_reg : !hit_valid) begin
                    r.error_code = ERR_MISSING;
                end else begin
                    r.is_valid = 1'b1;
                    r.is_waiting = 1'b0;
                    r.is_dirty = (op == OP_UPDATE);
                    if (op != OP_CLEAN) begin
                        r.found_physical_page = new_pp;
                        r.found_bitmap = new_bm;
                    end
                end
            end
            OP_RESERVE: begin
                if (hit_reg) r.error_code = ERR_DUP;
                else if (full) r.error_code = ERR_FULL;
                else if (free_found_reg) begin
                    r.is_waiting = 1'b1;
                    cnt_after = count_reg + 1'b1;
                end
            end
            OP_EVICT: begin
                if (count_reg == '0) r.error_code = ERR_EMPTY;
                else if (best_found_reg) begin
                    r.is_valid = !waiting_reg[best_idx_reg];
                    r.is_waiting = waiting_reg[best_idx_reg];
                    if (!waiting_reg[best_idx_reg]) begin
                        r.is_dirty = dirty_reg[best_idx_reg];
                        r.found_physical_page = ppage_rd_reg;
                        r.found_bitmap = bmap_rd_reg;
                    end
                    r.evicted_stream = strm_rd_reg;
                    r.evicted_logical_page = lpage_rd_reg;
                    cnt_after = count_reg - 1'b1;
                end
            end
            default: ;
        endcase
        r.slot_free = cnt_after < eff_cap;
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) rsp_reg <= r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_busy_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_busy_reg <= 1'b1;
        end else if (out_xfer) begin
            out_busy_reg <= 1'b0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(TableDepth))
        else $error("used count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (waiting_reg & ~used_reg) == '0)
        else $error("waiting flag on unused slot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CntW'($countones(used_reg)))
        else $error("used count out of step with used flags");
endmodule
`default_nettype wire

FILE: sv/lru_mapping_cache_table_unit.sv
// Top level of the LRU mapping cache table.
// Sequence from input transfer to result valid: slot scan, a settle state,
// a rank pass for retrieve and successful reserve, a slot read and the
// commit.
// Requests are taken only in idle, one at a time; the next input transfer is
// taken while the result waits, commit stalls only on a result still pending.
// Reset: aresetn synchronous, clears slot flags and used count, capacity 64.
`default_nettype none
module lru_mapping_cache_table_unit
    import lmct_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic [6:0] cfg_wdata,
    input  wire logic s_tvalid,
    output logic s_tready,
    // req_type[2:0], stream_number[5:3], logical_page[37:6],
    // physical_page[69:38], sector_bitmap[85:70]
    input  wire logic [87:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // is_valid, is_waiting, is_dirty, found_physical_page[34:3],
    // found_bitmap[50:35], slot_free[51], evicted_stream[54:52],
    // evicted_logical_page[86:55], error_code[89:87]
    output logic [95:0] m_tdata
);
    cmd_t cmd;
    sts_t sts;
    rsp_t rsp;
    req_t req;
    logic busy, in_xfer, out_xfer;

    assign in_xfer = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign m_tvalid = busy;
    assign req.req_type = s_tdata[2:0];
    assign req.stream_number = s_tdata[5:3];
    assign req.logical_page = s_tdata[37:6];
    assign req.physical_page = s_tdata[69:38];
    assign req.sector_bitmap = s_tdata[85:70];
    assign m_tdata = {6'd0, rsp.error_code, rsp.evicted_logical_page, rsp.evicted_stream,
                      rsp.slot_free, rsp.found_bitmap, rsp.found_physical_page,
                      rsp.is_dirty, rsp.is_waiting, rsp.is_valid};

    lmct_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_xfer(in_xfer), .out_busy(busy),
        .sts(sts), .cmd(cmd), .s_ready(s_tready)
    );

    lmct_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .req_in(req), .cfg_we(cfg_we),
        .cfg_data(cfg_wdata), .out_xfer(out_xfer), .sts(sts), .out_busy(busy), .rsp(rsp)
    );
endmodule
`default_nettype wire

FILE: verif/lmct_checker.sv
// Result checker for the LRU mapping cache table: tracks table state and compares results.
`default_nettype none
module lmct_checker
    import lmct_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic [6:0] cfg_wdata,
    input  wire logic s_tvalid,
    input  wire logic s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic m_tvalid,
    input  wire logic m_tready,
    input  wire logic [95:0] m_tdata,
    output int fail_count,
    output int pending_results
);
    logic [6:0] cap_reg;
    logic used_q [TableDepth];
    logic wait_q [TableDepth];
    logic dirty_q [TableDepth];
    logic [2:0] strm_q [TableDepth];
    logic [31:0] lpage_q [TableDepth];
    logic [31:0] ppage_q [TableDepth];
    logic [15:0] bmap_q [TableDepth];
    int rank_q [TableDepth];
    int used_cnt;
    rsp_t lookup_results [$];

    assign pending_results = lookup_results.size();

    function automatic int eff_cap();
        return (cap_reg > TableDepth) ? TableDepth : int'(cap_reg);
    endfunction

    function automatic req_t to_req(logic [87:0] d);
        return req_t'({d[2:0], d[5:3], d[37:6], d[69:38], d[85:70]});
    endfunction

    function automatic rsp_t to_rsp(logic [95:0] d);
        return rsp_t'({d[0], d[1], d[2], d[34:3], d[50:35], d[51], d[54:52],
                       d[86:55], d[89:87]});
    endfunction

    function automatic void show(int s, ref rsp_t r);
        r.is_valid = !wait_q[s];
        r.is_waiting = wait_q[s];
        if (!wait_q[s]) begin
            r.is_dirty = dirty_q[s];
            r.found_physical_page = ppage_q[s];
            r.found_bitmap = bmap_q[s];
        end
    endfunction

    function automatic rsp_t apply_request(req_t q);
        rsp_t r;
        int s;
        int best;
        logic [15:0] bm;
        logic ok;
        r = '0;
        s = -1;
        best = -1;
        bm = q.sector_bitmap & BitmapMask;
        for (int i = 0; i < TableDepth; i++) begin
            if (s < 0 && used_q[i] && strm_q[i] == q.stream_number
                    && lpage_q[i] == q.logical_page) begin
                s = i;
            end
        end
        ok = (s >= 0) && !wait_q[s];
        case (q.req_type)
            OP_QUERY, OP_RETRIEVE: begin
                if (s >= 0) show(s, r);
                if (!ok) begin
                    r.error_code = ERR_MISSING;
                end else if (q.req_type == OP_RETRIEVE) begin
                    for (int i = 0; i < TableDepth; i++)
                        if (used_q[i] && rank_q[i] < rank_q[s]) rank_q[i]++;
                    rank_q[s] = 0;
                end
            end
            OP_RESERVE: begin
                if (s >= 0) begin
                    r.error_code = ERR_DUP;
                end else if (used_cnt >= eff_cap()) begin
                    r.error_code = ERR_FULL;
                end else begin
                    for (int i = 0; i < TableDepth; i++)
                        if (used_q[i]) rank_q[i]++;
                    for (int i = 0; i < TableDepth; i++) begin
                        if (best < 0 && !used_q[i]) best = i;
                    end
                    if (best >= 0) begin
                        used_q[best] = 1;
                        wait_q[best] = 1;
                        dirty_q[best] = 0;
                        strm_q[best] = q.stream_number;
                        lpage_q[best] = q.logical_page;
                        rank_q[best] = 0;
                        used_cnt++;
                        r.is_waiting = 1;
                    end
                end
            end
            OP_FILL, OP_UPDATE, OP_CLEAN: begin
                if ((q.req_type == OP_FILL && s < 0) || (q.req_type != OP_FILL && !ok)) begin
                    r.error_code = ERR_MISSING;
                    if (s >= 0) show(s, r);
                end else begin
                    if (q.req_type != OP_CLEAN) begin
                        ppage_q[s] = q.physical_page;
                        bmap_q[s] = bm;
                    end
                    if (q.req_type == OP_FILL) wait_q[s] = 0;
                    dirty_q[s] = (q.req_type == OP_UPDATE);
                    show(s, r);
                end
            end
            OP_EVICT: begin
                if (used_cnt == 0) begin
                    r.error_code = ERR_EMPTY;
                end else begin
                    for (int i = 0; i < TableDepth; i++)
                        if (used_q[i] && (best < 0 || rank_q[i] > rank_q[best])) best = i;
                    show(best, r);
                    r.evicted_stream = strm_q[best];
                    r.evicted_logical_page = lpage_q[best];
                    used_q[best] = 0;
                    wait_q[best] = 0;
                    dirty_q[best] = 0;
                    used_cnt--;
                end
            end
            default: ;
        endcase
        r.slot_free = used_cnt < eff_cap();
        return r;
    endfunction

    task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        rsp_t e;
        rsp_t a;
        if (!aresetn) begin
            cap_reg = 7'd64;
            used_cnt = 0;
            for (int i = 0; i < TableDepth; i++) begin
                used_q[i] = 0;
                wait_q[i] = 0;
                dirty_q[i] = 0;
            end
            lookup_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) cap_reg = cfg_wdata;
            if (s_tvalid && s_tready) lookup_results.push_back(apply_request(to_req(s_tdata)));
            if (m_tvalid && m_tready) begin
                a = to_rsp(m_tdata);
                if (lookup_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end else begin
                    e = lookup_results.pop_front();
                    cmp("is_valid", e.is_valid, a.is_valid);
                    cmp("is_waiting", e.is_waiting, a.is_waiting);
                    cmp("is_dirty", e.is_dirty, a.is_dirty);
                    cmp("found_physical_page", e.found_physical_page, a.found_physical_page);
                    cmp("found_bitmap", e.found_bitmap, a.found_bitmap);
                    cmp("slot_free", e.slot_free, a.slot_free);
                    cmp("evicted_stream", e.evicted_stream, a.evicted_stream);
                    cmp("evicted_logical_page", e.evicted_logical_page, a.evicted_logical_page);
                    cmp("error_code", e.error_code, a.error_code);
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Stimulus and verdict for the LRU mapping cache table.
`default_nettype none
module tb;
    import lmct_pkg::*;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [6:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [87:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [95:0] m_tdata;
    int fail_count;
    int pending_results;
    int send_idle_pct;
    int recv_idle_pct;
    logic [2:0] key_strm [$];
    logic [31:0] key_page [$];

    lru_mapping_cache_table_unit uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lmct_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // leaves tvalid high after the transfer; the next call or drain() moves it
    task automatic send_req(logic [2:0] op, logic [2:0] st, logic [31:0] lp,
                            logic [31:0] pp, logic [15:0] bm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b0, bm, pp, lp, st, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_results != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [6:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic rand_req();
        logic [2:0] op;
        logic [2:0] st;
        logic [31:0] lp;
        int k;
        op = 3'($urandom_range(7));
        if (op == OP_UNUSED && $urandom_range(3) != 0) op = OP_FILL;
        if (key_strm.size() != 0 && $urandom_range(9) < 7) begin
            k = $urandom_range(key_strm.size() - 1);
            st = key_strm[k];
            lp = key_page[k];
        end else begin
            st = 3'($urandom);
            lp = ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(3));
            if (key_strm.size() < 80) begin
                key_strm.push_back(st);
                key_page.push_back(lp);
            end
        end
        send_req(op, st, lp, $urandom, 16'($urandom));
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty evict, misses, full lifecycle, extremes
        send_req(OP_EVICT, 0, 0, 0, 0);
        send_req(OP_QUERY, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_FILL, 1, 5, 1, 1);
        send_req(OP_RESERVE, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_RESERVE, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_QUERY, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_UPDATE, 7, 32'hFFFF_FFFF, 1, 1);
        send_req(OP_CLEAN, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_FILL, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(OP_RESERVE, 0, 0, 0, 0);
        send_req(OP_FILL, 0, 0, 0, 0);
        send_req(OP_UPDATE, 0, 0, 32'hA5A5_5A5A, 16'h8001);
        send_req(OP_RETRIEVE, 0, 0, 0, 0);
        send_req(OP_RETRIEVE, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_CLEAN, 0, 0, 0, 0);
        send_req(OP_FILL, 7, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_UNUSED, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(OP_RESERVE, 3, 9, 0, 0);
        send_req(OP_EVICT, 0, 0, 0, 0);
        send_req(OP_EVICT, 0, 0, 0, 0);
        send_req(OP_EVICT, 0, 0, 0, 0);
        send_req(OP_EVICT, 0, 0, 0, 0);

        // capacity 1: reserve, then full; capacity 0: full reserve, then evict
        set_capacity(7'd1);
        send_req(OP_RESERVE, 2, 2, 0, 0);
        send_req(OP_RESERVE, 2, 3, 0, 0);
        set_capacity(7'd0);
        send_req(OP_RESERVE, 2, 4, 0, 0);
        send_req(OP_EVICT, 0, 0, 0, 0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 24; recv_idle_pct = 56; end
                1: begin send_idle_pct = 56; recv_idle_pct = 24; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                0: set_capacity(7'd64);
                1: set_capacity(7'd127);
                2: set_capacity(7'd5);
                3: set_capacity(7'd1);
                4: set_capacity(7'(32 + $urandom_range(31)));
                default: set_capacity(7'd65);
            endcase
            key_strm.delete();
            key_page.delete();
            for (int n = 0; n < 200; n++) rand_req();
        end
        send_idle_pct = 0;
        drain();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
sv/lmct_pkg.sv
sv/lmct_ctrl.sv
sv/lmct_dp.sv
sv/lru_mapping_cache_table_unit.sv
verif/lmct_checker.sv
verif/tb.sv
